/* hw/rtl/adpcm2_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adpcm2_pkg
// Shared types and constants for the second-order ADPCM sample decoder:
// coefficient format, register indexes, reset values and operation codes.
// ----------------------------------------------------------------------------
package adpcm2_pkg;

   localparam int SAMPLES_PER_BLOCK_DEFAULT = 4;
   localparam int CODE_BITS_DEFAULT         = 3;

   localparam int COEF_WIDTH  = 18;
   localparam int COEF_FRAC   = 16;
   localparam int NUM_FILTERS = 4;
   localparam int FILT_W      = 2;
   localparam int SHIFT_W     = 4;
   localparam int HEADER_W    = 6;
   localparam int BYTE_W      = 8;
   localparam int DATA_W      = 32;
   localparam int SAMPLE_W    = 16;
   localparam int CSR_IDX_W   = 3;

   // Bit of the register index that selects the second-history bank.
   localparam int CSR_BANK_B_BIT = FILT_W;

   localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sd32767;
   localparam logic signed [DATA_W-1:0] SAT_MIN = -32'sd32768;

   typedef logic signed [COEF_WIDTH-1:0] coef_type;

   localparam coef_type COEF_A_RESET [NUM_FILTERS] = '{
      18'sd0, 18'sd61440, 18'sd124928, 18'sd117760
   };
   localparam coef_type COEF_B_RESET [NUM_FILTERS] = '{
      18'sd0, 18'sd0, -18'sd61440, -18'sd53248
   };

   typedef enum logic {
      OP_START  = 1'b0,
      OP_DECODE = 1'b1
   } op_type;

   function automatic logic signed [SAMPLE_W-1:0] sat16(
      input logic signed [DATA_W-1:0] v
   );
      logic signed [SAMPLE_W-1:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[SAMPLE_W-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[SAMPLE_W-1:0];
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/adpcm_second_order_decoder.sv */
// Sample items go from the input register to the result register. Throughput:
// one item per cycle unless a held result stalls; the history, running value
// and block state update in the single decode stage, so each sample feeds the
// next. A start item produces no result and never waits for the result
// register. Reset (synchronous, active high) clears all decode state and
// restores the default filter coefficients.
`default_nettype none
// ----------------------------------------------------------------------------
// adpcm_second_order_decoder
// Second-order ADPCM decoder with four programmable coefficient pairs, block
// headers that select shift and filter type, and a saturated running output.
// ----------------------------------------------------------------------------
module adpcm_second_order_decoder #(
   parameter int SAMPLES_PER_BLOCK = adpcm2_pkg::SAMPLES_PER_BLOCK_DEFAULT,
   parameter int CODE_BITS         = adpcm2_pkg::CODE_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,

   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic                                  req_operation,
   input  wire logic [adpcm2_pkg::BYTE_W-1:0]         req_initial_byte,
   input  wire logic [adpcm2_pkg::HEADER_W-1:0]       req_block_header,
   input  wire logic [CODE_BITS-1:0]                  req_sample_code,
   input  wire logic                                  req_last_in_signal,

   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [adpcm2_pkg::SAMPLE_W-1:0]     rsp_sample,
   output logic                                       rsp_end_of_signal,

   input  wire logic                                  csr_write_enable,
   input  wire logic [adpcm2_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [adpcm2_pkg::COEF_WIDTH-1:0]     csr_write_data
);
   import adpcm2_pkg::*;

   localparam int CNT_W = (SAMPLES_PER_BLOCK > 1) ? $clog2(SAMPLES_PER_BLOCK) : 1;
   localparam logic [CNT_W-1:0] CNT_RELOAD = CNT_W'(SAMPLES_PER_BLOCK - 1);

   typedef struct packed {
      op_type                  operation;
      logic [BYTE_W-1:0]       initial_byte;
      logic [HEADER_W-1:0]     block_header;
      logic [CODE_BITS-1:0]    sample_code;
      logic                    last_in_signal;
   } item_type;

   // Coefficient registers.
   coef_type coef_a_ff [NUM_FILTERS];
   coef_type coef_b_ff [NUM_FILTERS];

   // Input register.
   logic     in_valid_ff;
   item_type in_item_ff;

   // Decode state.
   logic signed [DATA_W-1:0] history_one_ff, history_one_in;
   logic signed [DATA_W-1:0] history_two_ff, history_two_in;
   logic signed [DATA_W-1:0] running_ff, running_in;
   logic [CNT_W-1:0]         countdown_ff, countdown_in;
   logic [SHIFT_W-1:0]       shift_ff, shift_in;
   logic [FILT_W-1:0]        filter_ff, filter_in;

   // Result register.
   logic                       out_valid_ff, out_valid_in;
   logic signed [SAMPLE_W-1:0] out_sample_ff, out_sample_in;
   logic                       out_end_ff, out_end_in;

   logic                       advance;
   logic                       is_decode;
   logic [SHIFT_W-1:0]         use_shift;
   logic [FILT_W-1:0]          use_filter;
   logic signed [DATA_W-1:0]   code_ext;
   logic signed [DATA_W-1:0]   resid;
   logic signed [DATA_W-1:0]   prod_a;
   logic signed [DATA_W-1:0]   prod_b;
   logic signed [DATA_W-1:0]   pred_sum;
   logic signed [DATA_W-1:0]   new_hist;
   logic signed [DATA_W-1:0]   new_running;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_FILTERS; i++) begin
            coef_a_ff[i] <= COEF_A_RESET[i];
            coef_b_ff[i] <= COEF_B_RESET[i];
         end
      end else if (csr_write_enable) begin
         if (csr_index[CSR_BANK_B_BIT]) begin
            coef_b_ff[csr_index[FILT_W-1:0]] <= csr_write_data;
         end else begin
            coef_a_ff[csr_index[FILT_W-1:0]] <= csr_write_data;
         end
      end
   end

   assign is_decode = (in_item_ff.operation == OP_DECODE);
   // A start item needs no room in the result register.
   assign advance   = in_valid_ff && (!is_decode || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_item_ff.operation      <= op_type'(req_operation);
         in_item_ff.initial_byte   <= req_initial_byte;
         in_item_ff.block_header   <= req_block_header;
         in_item_ff.sample_code    <= req_sample_code;
         in_item_ff.last_in_signal <= req_last_in_signal;
      end
   end

   // Decode datapath: header pickup, residual, prediction and accumulation.
   always_comb begin
      if (countdown_ff == '0) begin
         use_shift  = in_item_ff.block_header[SHIFT_W-1:0];
         use_filter = in_item_ff.block_header[SHIFT_W +: FILT_W];
      end else begin
         use_shift  = shift_ff;
         use_filter = filter_ff;
      end
      code_ext    = DATA_W'($signed(in_item_ff.sample_code));
      resid       = code_ext <<< use_shift;
      // Only the low 32 bits of each product count; products and sum wrap.
      prod_a      = history_one_ff * DATA_W'(coef_a_ff[use_filter]);
      prod_b      = history_two_ff * DATA_W'(coef_b_ff[use_filter]);
      pred_sum    = prod_a + prod_b;
      new_hist    = resid + (pred_sum >>> COEF_FRAC);
      new_running = running_ff + new_hist;
   end

   always_comb begin
      history_one_in = history_one_ff;
      history_two_in = history_two_ff;
      running_in     = running_ff;
      countdown_in   = countdown_ff;
      shift_in       = shift_ff;
      filter_in      = filter_ff;
      out_valid_in   = out_valid_ff && !rsp_ready;
      out_sample_in  = out_sample_ff;
      out_end_in     = out_end_ff;
      if (advance) begin
         if (is_decode) begin
            history_one_in = new_hist;
            history_two_in = history_one_ff;
            running_in     = new_running;
            shift_in       = use_shift;
            filter_in      = use_filter;
            countdown_in   = (countdown_ff == '0) ? CNT_RELOAD : countdown_ff - CNT_W'(1);
            out_valid_in   = 1'b1;
            out_sample_in  = sat16(new_running);
            out_end_in     = in_item_ff.last_in_signal;
         end else begin
            history_one_in = '0;
            history_two_in = '0;
            running_in     = DATA_W'($signed({in_item_ff.initial_byte, 8'h00}));
            countdown_in   = '0;
            shift_in       = '0;
            filter_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         history_one_ff <= '0;
         history_two_ff <= '0;
         running_ff     <= '0;
         countdown_ff   <= '0;
         shift_ff       <= '0;
         filter_ff      <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         history_one_ff <= history_one_in;
         history_two_ff <= history_two_in;
         running_ff     <= running_in;
         countdown_ff   <= countdown_in;
         shift_ff       <= shift_in;
         filter_ff      <= filter_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_sample_ff <= out_sample_in;
      out_end_ff    <= out_end_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_sample        = out_sample_ff;
   assign rsp_end_of_signal = out_end_ff;

endmodule
`default_nettype wire
